[sv/rrts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// shared constants and types for the round-robin thread scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int NUM_SLOTS_DEF = 16;

  localparam logic [2:0] FN_ADD   = 3'd0;
  localparam logic [2:0] FN_KILL  = 3'd1;
  localparam logic [2:0] FN_SLEEP = 3'd2;
  localparam logic [2:0] FN_YIELD = 3'd3;
  localparam logic [2:0] FN_TICK  = 3'd4;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_ACTIVE = 2'd1,
    ST_SLEEP  = 2'd2
  } slot_st_t;

endpackage

[sv/rrts_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/round_robin_thread_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// slot ring scheduler; link and id memories, the walk visits one slot at a time
// walk: a read then a check per slot followed on the link ram, at most NUM_SLOTS slots
// one item at a time: in_ready only in idle, after the result beat is taken
// reset: synchronous active low, all slots free, counters zero, no sweep
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
  parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_sleep_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [3:0]  out_running_slot,
  output logic [31:0] out_running_id,
  output logic        out_none_ready,
  output logic [4:0]  out_live_count
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_W1, S_ADD_W2, S_ADD_W3, S_KILL_RD, S_KILL_W1,
    S_KILL_W2, S_TICK, S_WALK_RD, S_WALK_CHK, S_ID_RD, S_ID_WT, S_OUT
  } state_t;

  state_t state_r;
  rrts_pkg::slot_st_t status_r [NUM_SLOTS];
  logic [31:0] sleep_r [NUM_SLOTS];
  logic [AW-1:0] running_r, last_r, cur_r, tmp_r, aux_r, free_s;
  logic [CW-1:0] total_r, walk_r;
  logic [31:0] idc_r;
  logic        free_found;
  logic        ok_r;

  // link rams: next and prev, one port each
  logic          nx_we, pv_we, id_we;
  logic [AW-1:0] nx_a, pv_a, id_a, nx_wd, pv_wd, nx_rd, pv_rd;
  logic [31:0]   id_rd;

  rrts_ram #(.DEPTH(NUM_SLOTS), .WIDTH(AW)) u_next (
    .clk(clk), .we(nx_we), .addr(nx_a), .wdata(nx_wd), .rdata(nx_rd));
  rrts_ram #(.DEPTH(NUM_SLOTS), .WIDTH(AW)) u_prev (
    .clk(clk), .we(pv_we), .addr(pv_a), .wdata(pv_wd), .rdata(pv_rd));
  rrts_ram #(.DEPTH(NUM_SLOTS), .WIDTH(32)) u_id (
    .clk(clk), .we(id_we), .addr(id_a), .wdata(idc_r), .rdata(id_rd));

  always_comb begin
    free_s     = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (status_r[i] == rrts_pkg::ST_FREE) begin
        free_s     = AW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    nx_we = 1'b0; pv_we = 1'b0; id_we = 1'b0;
    nx_a  = cur_r; pv_a = cur_r; id_a = running_r;
    nx_wd = '0; pv_wd = '0;
    unique case (state_r)
      S_ADD_RD:   nx_a = last_r;
      S_ADD_W1: begin
        nx_we = 1'b1; nx_a = cur_r; nx_wd = (total_r == '0) ? cur_r : nx_rd;
        pv_we = 1'b1; pv_a = cur_r; pv_wd = (total_r == '0) ? cur_r : last_r;
        id_we = 1'b1; id_a = cur_r;
      end
      S_ADD_W2: begin
        pv_we = 1'b1; pv_a = tmp_r; pv_wd = cur_r;
        nx_we = 1'b1; nx_a = last_r; nx_wd = cur_r;
      end
      S_KILL_RD: begin
        nx_a = running_r; pv_a = running_r;
      end
      S_KILL_W1: begin
        nx_we = 1'b1; nx_a = pv_rd; nx_wd = nx_rd;
        pv_we = 1'b1; pv_a = nx_rd; pv_wd = pv_rd;
      end
      S_WALK_RD:  nx_a = cur_r;
      default: ;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      running_r <= '0;
      last_r    <= '0;
      total_r   <= '0;
      idc_r     <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status_r[i] <= rrts_pkg::ST_FREE;
      end
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          ok_r   <= 1'b1;
          cur_r  <= running_r;
          walk_r <= '0;
          priority if (in_func == rrts_pkg::FN_ADD) begin
            if (total_r == '0) begin
              cur_r <= '0; state_r <= S_ADD_W1;
            end else if (free_found) begin
              cur_r <= free_s; state_r <= S_ADD_RD;
            end else begin
              ok_r <= 1'b0; state_r <= S_ID_RD;
            end
          end else if (in_func == rrts_pkg::FN_KILL ||
                       in_func == rrts_pkg::FN_SLEEP) begin
            if (total_r == '0 || status_r[running_r] == rrts_pkg::ST_FREE) begin
              ok_r <= 1'b0; state_r <= S_ID_RD;
            end else if (in_func == rrts_pkg::FN_KILL) begin
              state_r <= S_KILL_RD;
            end else begin
              if (in_sleep_ticks != '0) begin
                sleep_r[running_r]  <= in_sleep_ticks;
                status_r[running_r] <= rrts_pkg::ST_SLEEP;
              end
              state_r <= S_WALK_RD;
            end
          end else if (in_func == rrts_pkg::FN_YIELD) begin
            if (total_r == '0) begin
              ok_r <= 1'b0; state_r <= S_ID_RD;
            end else begin
              state_r <= S_WALK_RD;
            end
          end else if (in_func == rrts_pkg::FN_TICK) begin
            tmp_r <= '0; state_r <= S_TICK;
          end else begin
            ok_r <= 1'b0; state_r <= S_ID_RD;
          end
        end
        S_ADD_RD: state_r <= S_ADD_W1;
        S_ADD_W1: begin
          tmp_r <= nx_rd;
          status_r[cur_r] <= rrts_pkg::ST_ACTIVE;
          sleep_r[cur_r]  <= '0;
          idc_r   <= idc_r + 32'd1;
          total_r <= total_r + CW'(1);
          if (total_r == '0) begin
            running_r <= cur_r; last_r <= cur_r; state_r <= S_ID_RD;
          end else begin
            state_r <= S_ADD_W2;
          end
        end
        S_ADD_W2: begin
          last_r <= cur_r; state_r <= S_ID_RD;
        end
        S_KILL_RD: state_r <= S_KILL_W1;
        S_KILL_W1: begin
          if (last_r == running_r) last_r <= pv_rd;
          status_r[running_r] <= rrts_pkg::ST_FREE;
          total_r <= total_r - CW'(1);
          cur_r   <= running_r;
          state_r <= (total_r == CW'(1)) ? S_ID_RD : S_KILL_W2;
        end
        // extra state so the walk reads the repaired link
        S_KILL_W2: state_r <= S_WALK_RD;
        S_TICK: begin
          if (status_r[tmp_r] == rrts_pkg::ST_SLEEP) begin
            sleep_r[tmp_r] <= sleep_r[tmp_r] - 32'd1;
            if (sleep_r[tmp_r] == 32'd1) status_r[tmp_r] <= rrts_pkg::ST_ACTIVE;
          end
          tmp_r <= tmp_r + AW'(1);
          if (32'(tmp_r) == NUM_SLOTS - 1) begin
            state_r <= S_ID_RD;
            if (total_r != '0) begin
              if (status_r[running_r] == rrts_pkg::ST_SLEEP) begin
                if (!(tmp_r == running_r && sleep_r[tmp_r] == 32'd1))
                  state_r <= S_WALK_RD;
              end else if (status_r[running_r] != rrts_pkg::ST_ACTIVE) begin
                state_r <= S_WALK_RD;
              end
            end
          end
        end
        S_WALK_RD: state_r <= S_WALK_CHK;
        S_WALK_CHK: begin
          cur_r  <= nx_rd;
          walk_r <= walk_r + CW'(1);
          if (status_r[nx_rd] == rrts_pkg::ST_ACTIVE) begin
            running_r <= nx_rd; state_r <= S_ID_RD;
          end else if (walk_r == CW'(NUM_SLOTS - 1)) begin
            state_r <= S_ID_RD;
          end else begin
            state_r <= S_WALK_RD;
          end
        end
        S_ID_RD: state_r <= S_ID_WT;
        S_ID_WT: begin
          aux_r   <= running_r;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ok           = ok_r;
  assign out_running_slot = 4'(aux_r);
  assign out_running_id   = (status_r[aux_r] == rrts_pkg::ST_FREE) ? 32'd0 : id_rd;
  assign out_none_ready   = (status_r[aux_r] != rrts_pkg::ST_ACTIVE);
  assign out_live_count   = 5'(total_r);

endmodule

[tb/round_robin_thread_scheduler_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_test
// drives scheduler operations with random gaps on both channels and checks
// every result beat against an in-bench model of the slot ring
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_test;

  localparam int NS = rrts_pkg::NUM_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [31:0] id;
    logic        none_ready;
    logic [4:0]  live;
  } sched_res_t;

  class sched_scoreboard;
    rrts_pkg::slot_st_t status[NS];
    logic [31:0] left[NS];
    logic [31:0] ids[NS];
    logic [3:0]  nxt[NS];
    logic [3:0]  prv[NS];
    logic [3:0]  run;
    logic [3:0]  last;
    logic [4:0]  total;
    logic [31:0] id_next;
    sched_res_t  pending[$];
    int          errors;

    function void clear();
      for (int i = 0; i < NS; i++) begin
        status[i] = rrts_pkg::ST_FREE;
        left[i] = 0;
        ids[i] = 0;
        nxt[i] = 0;
        prv[i] = 0;
      end
      run = 0;
      last = 0;
      total = 0;
      id_next = 0;
      errors = 0;
    endfunction

    function void advance();
      logic [3:0] cur;
      cur = nxt[run];
      for (int i = 0; i < NS; i++) begin
        if (status[cur] == rrts_pkg::ST_ACTIVE) begin
          run = cur;
          return;
        end
        cur = nxt[cur];
      end
    endfunction

    function bit add_thread();
      int s;
      logic [3:0] after;
      if (total == 0) begin
        s = 0;
        nxt[0] = 0;
        prv[0] = 0;
        run = 0;
      end else begin
        s = NS;
        for (int i = NS - 1; i >= 0; i--) if (status[i] == rrts_pkg::ST_FREE) s = i;
        if (s == NS) return 0;
        after = nxt[last];
        nxt[s] = after;
        prv[s] = last;
        prv[after] = s[3:0];
        nxt[last] = s[3:0];
      end
      last = s[3:0];
      ids[s] = id_next;
      id_next++;
      status[s] = rrts_pkg::ST_ACTIVE;
      left[s] = 0;
      total++;
      return 1;
    endfunction

    function void note_beat(logic [2:0] fn, logic [31:0] ticks);
      sched_res_t r;
      logic [3:0] p, n;
      r.ok = 0;
      case (fn)
        rrts_pkg::FN_ADD: r.ok = add_thread();
        rrts_pkg::FN_KILL: begin
          if (total != 0 && status[run] != rrts_pkg::ST_FREE) begin
            p = prv[run];
            n = nxt[run];
            if (last == run) last = p;
            status[run] = rrts_pkg::ST_FREE;
            nxt[p] = n;
            prv[n] = p;
            total--;
            if (total != 0) advance();
            r.ok = 1;
          end
        end
        rrts_pkg::FN_SLEEP: begin
          if (total != 0 && status[run] != rrts_pkg::ST_FREE) begin
            if (ticks != 0) begin
              left[run] = ticks;
              status[run] = rrts_pkg::ST_SLEEP;
            end
            advance();
            r.ok = 1;
          end
        end
        rrts_pkg::FN_YIELD: begin
          if (total != 0) begin
            advance();
            r.ok = 1;
          end
        end
        rrts_pkg::FN_TICK: begin
          for (int i = 0; i < NS; i++) begin
            if (status[i] == rrts_pkg::ST_SLEEP) begin
              left[i]--;
              if (left[i] == 0) status[i] = rrts_pkg::ST_ACTIVE;
            end
          end
          if (total != 0 && status[run] != rrts_pkg::ST_ACTIVE) advance();
          r.ok = 1;
        end
        default: r.ok = 0;
      endcase
      r.slot = run;
      r.id = (status[run] == rrts_pkg::ST_FREE) ? 32'd0 : ids[run];
      r.none_ready = (status[run] != rrts_pkg::ST_ACTIVE);
      r.live = total;
      pending.push_back(r);
    endfunction

    function void check_beat(sched_res_t got);
      sched_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp ok=%0d slot=%0d id=%h nr=%0d live=%0d, ",
                    "got ok=%0d slot=%0d id=%h nr=%0d live=%0d"},
                   want.ok, want.slot, want.id, want.none_ready, want.live,
                   got.ok, got.slot, got.id, got.none_ready, got.live);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_func = 0;
  logic [31:0] in_sleep_ticks = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        out_ok;
  logic [3:0]  out_running_slot;
  logic [31:0] out_running_id;
  logic        out_none_ready;
  logic [4:0]  out_live_count;

  sched_scoreboard sb;
  int cycles = 0;
  bit calm = 0;

  round_robin_thread_scheduler dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[round_robin_thread_scheduler] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_beat('{out_ok, out_running_slot, out_running_id, out_none_ready,
                      out_live_count});
  end

  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        w = calm ? 0 : $urandom_range(0, 8);
        if (w != 0) begin
          out_ready <= 0;
          repeat (w) @(posedge clk);
        end
      end
      out_ready <= 1;
    end
  end

  task automatic send_op(logic [2:0] fn, logic [31:0] ticks);
    int w;
    w = calm ? 0 : $urandom_range(0, 8);
    if (w != 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= fn;
    in_sleep_ticks <= ticks;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(fn, ticks);
  endtask

  function automatic logic [31:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  initial begin
    int r;
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty ring cases first
    send_op(rrts_pkg::FN_KILL, 0);
    send_op(rrts_pkg::FN_SLEEP, 5);
    send_op(rrts_pkg::FN_YIELD, 0);
    send_op(rrts_pkg::FN_TICK, 0);
    send_op(3'd5, 32'hffff_ffff);
    send_op(3'd7, 0);
    send_op(rrts_pkg::FN_ADD, 0);
    send_op(rrts_pkg::FN_SLEEP, 0);
    send_op(rrts_pkg::FN_SLEEP, 2);
    send_op(rrts_pkg::FN_SLEEP, 3);
    send_op(rrts_pkg::FN_TICK, 0);
    send_op(rrts_pkg::FN_TICK, 0);
    send_op(rrts_pkg::FN_TICK, 0);
    for (int i = 0; i < 16; i++) send_op(rrts_pkg::FN_ADD, 0);
    send_op(rrts_pkg::FN_SLEEP, 32'hffff_ffff);
    send_op(rrts_pkg::FN_KILL, 0);
    send_op(rrts_pkg::FN_YIELD, 0);
    send_op(3'd6, 32'h8000_0001);
    // random: mostly valid ops on a populated ring
    for (int i = 0; i < 900; i++) begin
      calm = (i % 200) > 170;
      r = $urandom_range(0, 99);
      if (r < 28) send_op(rrts_pkg::FN_ADD, $urandom);
      else if (r < 40) send_op(rrts_pkg::FN_KILL, $urandom);
      else if (r < 58) send_op(rrts_pkg::FN_SLEEP, pick_ticks());
      else if (r < 72) send_op(rrts_pkg::FN_YIELD, $urandom);
      else if (r < 96) send_op(rrts_pkg::FN_TICK, $urandom);
      else send_op(3'($urandom_range(5, 7)), $urandom);
    end
    in_valid <= 0;
    calm = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[round_robin_thread_scheduler] OK");
    else
      $display("[round_robin_thread_scheduler] ERROR");
    $finish;
  end

endmodule
